@@ rtl/palette_gradient_color_macros.svh @@
// Assertion macros used by the palette gradient colour top level.
`ifndef PALETTE_GRADIENT_COLOR_MACROS_SVH
`define PALETTE_GRADIENT_COLOR_MACROS_SVH

// Check a property on every rising edge once reset is released
`define PGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define PGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/pgc_pkg.sv @@
// Shared types and constants of the palette gradient colour block.
package pgc_pkg;

  localparam int SPAN_W    = 8;
  localparam int POS_W     = 8;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int NUM_STOPS = 4;
  localparam int RGB_W     = NUM_CH * CH_W;
  localparam int CFG_IDX_W = 3;

  // Segment length is span / 3, done as span * 171 >> 9 (exact for spans below 512)
  localparam int SEG_W       = 7;
  localparam int OFF_W       = 7;
  localparam int SEG_RECIP   = 171;
  localparam int SEG_SHIFT   = 9;
  localparam int SEG_PROD_W  = 16;

  // Magnitude of the channel step times the offset, and the divider layout
  localparam int PROD_W     = CH_W + OFF_W;
  localparam int DSH_W      = PROD_W + 1;
  localparam int QUO_W      = CH_W;
  localparam int BPS        = 2;
  localparam int DIV_STAGES = QUO_W / BPS;
  localparam int PIPE_DEPTH = DIV_STAGES + 1;

  // Queues
  localparam int TQ_DEPTH = 2;
  localparam int TQ_PTR_W = 1;
  localparam int TQ_CNT_W = 2;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = 3;
  localparam int OQ_CNT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPAN  = 3'd0,
    REG_STOP0 = 3'd1,
    REG_STOP1 = 3'd2,
    REG_STOP2 = 3'd3,
    REG_STOP3 = 3'd4
  } cfg_reg_e;

  // Channel 2 is red, 1 green, 0 blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic [SPAN_W-1:0]        span;
    rgb_t [NUM_STOPS-1:0]     stop;
  } cfg_t;

  localparam logic [SPAN_W-1:0] SPAN_RST  = 8'd125;
  localparam rgb_t              STOP0_RST = 24'hE73900;
  localparam rgb_t              STOP1_RST = 24'hE78C00;
  localparam rgb_t              STOP2_RST = 24'hE7E100;
  localparam rgb_t              STOP3_RST = 24'hE73900;

  localparam cfg_t CFG_RST = '{
    span: SPAN_RST,
    stop: {STOP3_RST, STOP2_RST, STOP1_RST, STOP0_RST}
  };

  // One classified item handed from the front to the back
  typedef struct packed {
    logic                        pass;
    rgb_t                        base;
    logic [NUM_CH-1:0]           neg;
    logic [NUM_CH-1:0][CH_W-1:0] mag;
    logic [OFF_W-1:0]            off;
    logic [SEG_W-1:0]            seg;
  } task_t;

  typedef struct packed {
    logic busy;
    logic stalled;
  } front_stat_t;

  typedef struct packed {
    logic [OQ_CNT_W-1:0] occupancy;
    logic                issue;
  } back_stat_t;

endpackage

@@ rtl/pgc_front.sv @@
// Front end: takes a position, finds its segment and offset, classifies it.
module pgc_front import pgc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              push_i,
  input  logic [POS_W-1:0]  position_i,
  output logic              full_o,
  output task_t             task_o,
  output logic              task_valid_o,
  input  logic              task_ready_i,
  output front_stat_t       stat_o
);

  logic [SEG_PROD_W-1:0] seg_prod;
  logic [SEG_W-1:0]      seg;
  logic [SEG_W:0]        seg2;
  logic [SEG_W+1:0]      seg3;
  logic [POS_W:0]        pos_ext;
  logic [POS_W-1:0]      off_full;
  logic [1:0]            sec;
  logic [1:0]            sec_next;
  rgb_t                  from_rgb;
  rgb_t                  to_rgb;
  task_t                 task_d;
  task_t                 task_q;
  logic                  tv_q;
  logic                  accept;

  // Segment length and its multiples
  assign seg_prod = SEG_PROD_W'(cfg_i.span) * SEG_PROD_W'(SEG_RECIP);
  assign seg      = seg_prod[SEG_SHIFT +: SEG_W];
  assign seg2     = {seg, 1'b0};
  assign seg3     = {1'b0, seg2} + {2'b00, seg};
  assign pos_ext  = {1'b0, position_i};

  // Pick the segment and the offset inside it
  always_comb begin
    priority if (pos_ext < {2'b00, seg}) begin
      sec      = 2'd0;
      off_full = position_i;
    end else if (pos_ext < {1'b0, seg2}) begin
      sec      = 2'd1;
      off_full = position_i - {1'b0, seg};
    end else begin
      sec      = 2'd2;
      off_full = position_i - seg2;
    end
  end

  assign sec_next = sec + 2'd1;
  assign from_rgb = cfg_i.stop[sec];
  assign to_rgb   = cfg_i.stop[sec_next];

  // Build the task: past the last segment or a zero segment reads the last stop
  always_comb begin
    task_d.pass = (seg == '0) || ({1'b0, pos_ext} >= {1'b0, seg3});
    task_d.base = task_d.pass ? cfg_i.stop[NUM_STOPS-1] : from_rgb;
    task_d.off  = off_full[OFF_W-1:0];
    task_d.seg  = seg;
    for (int c = 0; c < NUM_CH; c++) begin
      task_d.neg[c] = to_rgb[c] < from_rgb[c];
      task_d.mag[c] = task_d.neg[c] ? (from_rgb[c] - to_rgb[c]) : (to_rgb[c] - from_rgb[c]);
    end
  end

  // Hold the stage while the queue is full
  assign full_o = tv_q && !task_ready_i;
  assign accept = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
    end else if (accept) begin
      tv_q <= 1'b1;
    end else if (task_ready_i) begin
      tv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      task_q <= task_d;
    end
  end

  assign task_o         = task_q;
  assign task_valid_o   = tv_q;
  assign stat_o.busy    = tv_q;
  assign stat_o.stalled = full_o;

endmodule

@@ rtl/pgc_task_queue.sv @@
// Short queue of classified items between the front and the back.
module pgc_task_queue import pgc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output task_t data_o,
  output logic  empty_o
);

  task_t               mem_q [TQ_DEPTH];
  logic [TQ_PTR_W-1:0] wr_ptr_q;
  logic [TQ_PTR_W-1:0] rd_ptr_q;
  logic [TQ_CNT_W-1:0] cnt_q;
  logic [TQ_CNT_W-1:0] cnt_d;
  logic                wr_en;
  logic                rd_en;

  assign full_o  = cnt_q == TQ_CNT_W'(TQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Track the fill level
  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Store the transfer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/pgc_back.sv @@
// Back end: multiply, pipelined divide, blend and the result queue.
module pgc_back import pgc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  task_t             task_i,
  input  logic              task_valid_i,
  output logic              task_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [CH_W-1:0]   red_o,
  output logic [CH_W-1:0]   green_o,
  output logic [CH_W-1:0]   blue_o,
  output back_stat_t        stat_o
);

  typedef struct packed {
    logic                          pass;
    rgb_t                          base;
    logic [NUM_CH-1:0]             neg;
    logic [SEG_W-1:0]              seg;
    logic [NUM_CH-1:0][PROD_W-1:0] rem;
    logic [NUM_CH-1:0][QUO_W-1:0]  quo;
  } div_t;

  div_t                st_q [PIPE_DEPTH];
  div_t                st_d [PIPE_DEPTH];
  logic [PIPE_DEPTH-1:0] v_q;
  rgb_t                color;
  rgb_t                oq_mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_q;
  logic [OQ_PTR_W-1:0] oq_rd_q;
  logic [OQ_CNT_W-1:0] oq_cnt_q;
  logic [OQ_CNT_W-1:0] oq_cnt_d;
  logic [OQ_CNT_W-1:0] occupancy;
  logic                issue;
  logic                oq_wr;
  logic                oq_rd;

  // Count items in flight plus waiting results, and issue only with room left
  always_comb begin
    occupancy = oq_cnt_q;
    for (int s = 0; s < PIPE_DEPTH; s++) begin
      occupancy = occupancy + OQ_CNT_W'(v_q[s]);
    end
  end

  assign issue      = task_valid_i && (occupancy < OQ_CNT_W'(OQ_DEPTH));
  assign task_pop_o = issue;

  always_comb begin : div_steps
    logic [DSH_W-1:0] dsh;
    int               bit_idx;
    dsh     = '0;
    bit_idx = 0;
    // Stage 0: step magnitude times offset
    st_d[0].pass = task_i.pass;
    st_d[0].base = task_i.base;
    st_d[0].neg  = task_i.neg;
    st_d[0].seg  = task_i.seg;
    st_d[0].quo  = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      st_d[0].rem[c] = PROD_W'(task_i.mag[c]) * PROD_W'(task_i.off);
    end
    // Divide stages: resolve two quotient bits each by restoring subtraction
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      st_d[k] = st_q[k-1];
      for (int b = 0; b < BPS; b++) begin
        bit_idx = QUO_W - 1 - (k - 1) * BPS - b;
        dsh     = DSH_W'(st_q[k-1].seg) << bit_idx;
        for (int c = 0; c < NUM_CH; c++) begin
          if ({1'b0, st_d[k].rem[c]} >= dsh) begin
            st_d[k].rem[c]          = st_d[k].rem[c] - dsh[PROD_W-1:0];
            st_d[k].quo[c][bit_idx] = 1'b1;
          end
        end
      end
    end
  end

  // Advance the pipeline every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[PIPE_DEPTH-2:0], issue};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < PIPE_DEPTH; s++) begin
      st_q[s] <= st_d[s];
    end
  end

  // Blend: start plus or minus the truncated quotient, or the base alone for a pass item
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (st_q[PIPE_DEPTH-1].pass) begin
        color[c] = st_q[PIPE_DEPTH-1].base[c];
      end else if (st_q[PIPE_DEPTH-1].neg[c]) begin
        color[c] = st_q[PIPE_DEPTH-1].base[c] - st_q[PIPE_DEPTH-1].quo[c];
      end else begin
        color[c] = st_q[PIPE_DEPTH-1].base[c] + st_q[PIPE_DEPTH-1].quo[c];
      end
    end
  end

  // Result queue
  assign oq_wr   = v_q[PIPE_DEPTH-1];
  assign empty_o = oq_cnt_q == '0;
  assign oq_rd   = pop_i && !empty_o;

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_wr && !oq_rd) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (oq_rd && !oq_wr) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (oq_wr) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_rd) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr) begin
      oq_mem_q[oq_wr_q] <= color;
    end
  end

  assign red_o   = oq_mem_q[oq_rd_q][2];
  assign green_o = oq_mem_q[oq_rd_q][1];
  assign blue_o  = oq_mem_q[oq_rd_q][0];

  assign stat_o.occupancy = occupancy;
  assign stat_o.issue     = issue;

endmodule

@@ rtl/palette_gradient_color.sv @@
// Top level of the four-stop palette gradient colour block.
//
//   channel   handshake           payload
//   input     push / full         position_i
//   result    pop / empty         red_o, green_o, blue_o
//   config    cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while results are popped; a result becomes poppable
// after the front stage, task queue, multiply and four two-bit divide stages.
// The divide pipeline never stalls; issue from the task queue waits for room
// in the eight-entry result queue, so a stalled result side fills the task
// queue and then raises full. Reset clears all queues and loads the default
// palette and span.
module palette_gradient_color import pgc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [POS_W-1:0]     position_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [CH_W-1:0]      red_o,
  output logic [CH_W-1:0]      green_o,
  output logic [CH_W-1:0]      blue_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RGB_W-1:0]     cfg_wdata_i
);

`include "palette_gradient_color_macros.svh"

  cfg_t        cfg_q;
  task_t       front_task;
  logic        front_valid;
  logic        tq_full;
  task_t       tq_task;
  logic        tq_empty;
  logic        tq_pop;
  front_stat_t front_stat;
  back_stat_t  back_stat;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SPAN:  cfg_q.span    <= cfg_wdata_i[SPAN_W-1:0];
        REG_STOP0: cfg_q.stop[0] <= cfg_wdata_i;
        REG_STOP1: cfg_q.stop[1] <= cfg_wdata_i;
        REG_STOP2: cfg_q.stop[2] <= cfg_wdata_i;
        REG_STOP3: cfg_q.stop[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pgc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .position_i   (position_i),
    .full_o       (full),
    .task_o       (front_task),
    .task_valid_o (front_valid),
    .task_ready_i (!tq_full),
    .stat_o       (front_stat)
  );

  pgc_task_queue u_task_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_task),
    .full_o  (tq_full),
    .pop_i   (tq_pop),
    .data_o  (tq_task),
    .empty_o (tq_empty)
  );

  pgc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_i       (tq_task),
    .task_valid_i (!tq_empty),
    .task_pop_o   (tq_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .stat_o       (back_stat)
  );

  // Results in flight never exceed the result queue
  `PGC_ASSERT_ALWAYS(a_occupancy_bound, (back_stat.occupancy <= OQ_CNT_W'(OQ_DEPTH)), "result queue overbooked")
  // An accepted transfer occupies the front stage next cycle
  `PGC_ASSERT(a_accept_lands, (push && !full) |=> front_stat.busy, "accepted item lost at front")
  // A waiting result implies the back has it booked
  `PGC_ASSERT(a_result_booked, !empty |-> (back_stat.occupancy != '0), "result without booking")
  // Issue only from a non-empty task queue
  `PGC_ASSERT(a_issue_has_task, back_stat.issue |-> !tq_empty, "issue from empty task queue")
  // A stalled front always holds an item
  `PGC_ASSERT(a_stall_holds, front_stat.stalled |-> front_stat.busy, "front stalled while idle")

endmodule
